### hw/rtl/ppws_pkg.sv
// Shared types, constants and a helper function of the pure-pursuit steering block.
`default_nettype none
package ppws_pkg;

  parameter int MAX_POINTS_DEF = 1024;

  parameter int POS_W    = 32;
  parameter int DIST_W   = 33;
  parameter int CORDIC_W = 54;
  parameter int CZ_W     = 28;
  parameter int ANGLE_W  = 20;
  parameter int SINE_W   = 18;
  parameter int ALPHA_W  = 22;
  parameter int STEER_W  = 16;
  parameter int CFG_W    = 31;
  parameter int CORDIC_N = 24;

  typedef logic signed [ALPHA_W-1:0] alpha_t;
  parameter alpha_t PI_Q16      = 22'sd205887;
  parameter alpha_t TWO_PI_Q16  = 22'sd411775;
  parameter alpha_t HALF_PI_Q16 = 22'sd102944;

  parameter logic signed [CZ_W-1:0]     PI_Q24      = 28'sd52707179;
  parameter logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 54'sd652032874;
  parameter logic signed [ANGLE_W-1:0]  STEER_LIMIT = 20'sd26214;

  parameter logic        ENABLED_RST   = 1'b1;
  parameter logic [15:0] VELOCITY_GAIN_RST = 16'd26214;
  parameter logic [30:0] LOOKAHEAD_RST = 31'd131072;
  parameter logic [30:0] WHEEL_BASE_RST = 31'd21627;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_POSE = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_ENABLED       = 2'd0,
    CFG_VELOCITY_GAIN = 2'd1,
    CFG_LOOKAHEAD     = 2'd2,
    CFG_WHEEL_BASE    = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POSE_MUL,
    ST_POSE_ATAN,
    ST_POSE_WAIT,
    ST_NEAR,
    ST_WALK,
    ST_GOAL_RD,
    ST_GOAL_DATA,
    ST_BEAR_START,
    ST_BEAR_WAIT,
    ST_ALPHA,
    ST_SIN_START,
    ST_SIN_WAIT,
    ST_STEER_MUL,
    ST_STEER_START,
    ST_STEER_WAIT
  } state_t;

  typedef struct packed {
    logic                         start;
    logic                         vec;
    logic signed [CORDIC_W-1:0]   x0;
    logic signed [CORDIC_W-1:0]   y0;
    logic signed [CZ_W-1:0]       z0;
  } cordic_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [ANGLE_W-1:0]    angle;
    logic signed [SINE_W-1:0]     sine;
  } cordic_rsp_t;

  function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ppws_in_if.sv
// Input channel: command beats with waypoint, pose or tick payload.
`default_nettype none
interface ppws_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [9:0]         point_index;
  logic               point_last;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] point_speed;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, action, point_index, point_last, pos_x, pos_y,
                  point_speed, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, action, point_index, point_last, pos_x, pos_y,
                point_speed, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

### hw/rtl/ppws_out_if.sv
// Output channel: drive command beats.
`default_nettype none
interface ppws_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_speed;
  logic signed [15:0] steer_angle;

  modport source (output valid, drive_speed, steer_angle, input ready);
  modport sink (input valid, drive_speed, steer_angle, output ready);
endinterface
`default_nettype wire

### hw/rtl/ppws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ppws_ram #(
  parameter int WIDTH = ppws_pkg::POS_W,
  parameter int DEPTH = ppws_pkg::MAX_POINTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/ppws_dist.sv
// Pipelined Euclidean distance: squares, sum and a one-bit-per-stage floor square root.
`default_nettype none
module ppws_dist #(
  parameter int TAG_W = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_vld,
  input  wire logic signed [ppws_pkg::DIST_W-1:0]    in_dx,
  input  wire logic signed [ppws_pkg::DIST_W-1:0]    in_dy,
  input  wire logic [TAG_W-1:0]                      in_tag,
  output logic                                       out_vld,
  output logic [ppws_pkg::DIST_W-1:0]                out_dist,
  output logic [TAG_W-1:0]                           out_tag
);
  localparam int NS = 32;

  logic              p0_vld, p1_vld;
  logic              p0_sh, p1_sh;
  logic [TAG_W-1:0]  p0_tag, p1_tag;
  logic [30:0]       p0_a, p0_b;
  logic [61:0]       p1_aa, p1_bb;

  logic              st_vld [0:NS];
  logic              st_sh  [0:NS];
  logic [TAG_W-1:0]  st_tag [0:NS];
  logic [33:0]       st_rem [0:NS];
  logic [31:0]       st_root [0:NS];
  logic [63:0]       st_n   [0:NS];

  logic [32:0] abs_x, abs_y;
  logic        big;

  always_comb begin
    abs_x = in_dx[32] ? 33'(-in_dx) : 33'(in_dx);
    abs_y = in_dy[32] ? 33'(-in_dy) : 33'(in_dy);
    big   = (abs_x[32:31] != 2'b00) || (abs_y[32:31] != 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
      p1_vld <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        st_vld[k] <= 1'b0;
      end
    end else begin
      p0_vld    <= in_vld;
      p1_vld    <= p0_vld;
      st_vld[0] <= p1_vld;
      for (int k = 1; k <= NS; k++) begin
        st_vld[k] <= st_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin : pipe
    logic [33:0] rem2;
    logic [33:0] trial;
    p0_sh  <= big;
    p0_tag <= in_tag;
    p0_a   <= big ? abs_x[31:1] : abs_x[30:0];
    p0_b   <= big ? abs_y[31:1] : abs_y[30:0];

    p1_sh  <= p0_sh;
    p1_tag <= p0_tag;
    p1_aa  <= p0_a * p0_a;
    p1_bb  <= p0_b * p0_b;

    st_sh[0]   <= p1_sh;
    st_tag[0]  <= p1_tag;
    st_rem[0]  <= '0;
    st_root[0] <= '0;
    st_n[0]    <= 64'(p1_aa) + 64'(p1_bb);

    for (int k = 1; k <= NS; k++) begin
      rem2  = {st_rem[k-1][31:0], st_n[k-1][63:62]};
      trial = {st_root[k-1], 2'b01};
      st_sh[k]  <= st_sh[k-1];
      st_tag[k] <= st_tag[k-1];
      st_n[k]   <= {st_n[k-1][61:0], 2'b00};
      if (rem2 >= trial) begin
        st_rem[k]  <= rem2 - trial;
        st_root[k] <= {st_root[k-1][30:0], 1'b1};
      end else begin
        st_rem[k]  <= rem2;
        st_root[k] <= {st_root[k-1][30:0], 1'b0};
      end
    end
  end

  assign out_vld  = st_vld[NS];
  assign out_tag  = st_tag[NS];
  assign out_dist = st_sh[NS] ? {st_root[NS], 1'b0} : {1'b0, st_root[NS]};
endmodule
`default_nettype wire

### hw/rtl/ppws_cordic.sv
// Shared iterative CORDIC: vectoring gives atan2, rotation gives sine.
`default_nettype none
module ppws_cordic (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ppws_pkg::cordic_req_t req,
  output ppws_pkg::cordic_rsp_t      rsp
);
  localparam int W  = ppws_pkg::CORDIC_W;
  localparam int ZW = ppws_pkg::CZ_W;

  logic                busy, done_r;
  logic                vec_r, zero_r;
  logic [4:0]          iter;
  logic signed [W-1:0] x, y;
  logic signed [ZW-1:0] z;

  logic signed [W-1:0]  xs, ys;
  logic signed [ZW-1:0] tab;
  logic                 sel;
  logic signed [ZW-1:0] z_rnd;
  logic signed [W-1:0]  y_rnd;

  always_comb begin
    xs    = x >>> iter;
    ys    = y >>> iter;
    tab   = ppws_pkg::atan_q24(iter);
    sel   = vec_r ? (y > 0) : (z < 0);
    z_rnd = (z + 28'sd128) >>> 8;
    y_rnd = (y + 54'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && iter == 5'(ppws_pkg::CORDIC_N - 1)) begin
        busy   <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      iter   <= '0;
      vec_r  <= req.vec;
      zero_r <= (req.x0 == '0) && (req.y0 == '0);
      if (!req.vec) begin
        x <= ppws_pkg::CORDIC_K_Q30;
        y <= '0;
        z <= req.z0;
      end else if (req.x0 < 0) begin
        x <= -req.x0;
        y <= -req.y0;
        z <= (req.y0 >= 0) ? ppws_pkg::PI_Q24 : -ppws_pkg::PI_Q24;
      end else begin
        x <= req.x0;
        y <= req.y0;
        z <= '0;
      end
    end else if (busy) begin
      iter <= iter + 5'd1;
      if (sel) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tab;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tab;
      end
    end
  end

  always_comb begin
    rsp.done  = done_r;
    rsp.angle = zero_r ? '0 : z_rnd[ppws_pkg::ANGLE_W-1:0];
    if (y_rnd > 54'sd65536) begin
      rsp.sine = 18'sd65536;
    end else if (y_rnd < -54'sd65536) begin
      rsp.sine = -18'sd65536;
    end else begin
      rsp.sine = y_rnd[ppws_pkg::SINE_W-1:0];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/pure_pursuit_waypoint_steering.sv
// Top level: waypoint table, pose register and the pure-pursuit tick sequencer.
// A load is written in the idle state; a pose update forms the quaternion products, then runs
// one CORDIC pass for the heading; one item at a time. A tick runs the nearest scan and then the
// ring walk, each streaming one table read per cycle through the 35-stage distance pipeline; then
// goal distance with bearing, sine and steering follow; a held output beat stalls the last step.
// Reset restores the register defaults and clears count, pose and flags; tables are not cleared.
`default_nettype none
module pure_pursuit_waypoint_steering #(
  parameter int MAX_POINTS = ppws_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [ppws_pkg::CFG_W-1:0] cfg_data,
  ppws_in_if.sink          in_ch,
  ppws_out_if.source       out_ch
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = ppws_pkg::DIST_W;
  localparam int W  = ppws_pkg::CORDIC_W;

  ppws_pkg::state_t state, state_next;

  logic        enabled;
  logic [15:0] velocity_gain;
  logic [30:0] lookahead_dist;
  logic [30:0] wheel_base;

  logic [CW-1:0]      point_count;
  logic               have_points, have_pose;
  logic signed [31:0] car_x, car_y;
  logic signed [ppws_pkg::ANGLE_W-1:0] car_heading;

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;

  logic [CW:0]   issue_cnt;
  logic [CW-1:0] recv_cnt;
  logic [AW-1:0] rd_addr, rd_tag, nearest, goal;
  logic          rd_pend, rd_first, found, got_b, got_ld;
  logic [DW-1:0] best, ld;
  logic [33:0]   acc;
  logic signed [31:0] prev_x, prev_y, spd;
  logic signed [DW-1:0] dx_l, dy_l;
  logic signed [ppws_pkg::ANGLE_W-1:0] bearing;
  ppws_pkg::alpha_t alpha;
  logic signed [ppws_pkg::SINE_W-1:0] sin_v;
  logic signed [50:0] steer_y;
  logic signed [48:0] spd_prod;

  logic               out_valid;
  logic signed [31:0] out_drive;
  logic signed [15:0] out_steer;

  logic in_ready, accept, out_free, issue;
  logic ram_we, idx_ok;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   xy_rdata;
  logic [31:0]   spd_rdata;
  logic signed [31:0] ram_x, ram_y;

  logic                 dist_vld, dout_vld;
  logic signed [DW-1:0] dist_dx, dist_dy;
  logic [AW-1:0]        dist_tag, dout_tag;
  logic [DW-1:0]        dout_dist;

  ppws_pkg::cordic_req_t creq;
  ppws_pkg::cordic_rsp_t crsp;

  logic          last_recv, near_upd, hit, steer_done;
  logic [AW-1:0] near_idx;
  logic [33:0]   acc_next;
  ppws_pkg::alpha_t alpha_c, alpha_w, alpha_f;
  logic signed [49:0] steer_prod_c, sp_sum, sp_sh;
  logic signed [48:0] spd_prod_c;
  logic signed [33:0] pose_num, pose_den;

  assign accept    = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign out_free  = !out_valid || out_ch.ready;
  assign idx_ok    = 32'(in_ch.point_index) < 32'(MAX_POINTS);
  assign ram_we    = accept && (in_ch.action == ppws_pkg::ACT_LOAD) && idx_ok;
  assign ram_x     = xy_rdata[63:32];
  assign ram_y     = xy_rdata[31:0];

  ppws_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_xy_ram (
    .clk(clk), .we(ram_we), .waddr(AW'(in_ch.point_index)),
    .wdata({in_ch.pos_x, in_ch.pos_y}), .raddr(mem_raddr), .rdata(xy_rdata)
  );

  ppws_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_spd_ram (
    .clk(clk), .we(ram_we), .waddr(AW'(in_ch.point_index)),
    .wdata(in_ch.point_speed), .raddr(mem_raddr), .rdata(spd_rdata)
  );

  ppws_dist #(.TAG_W(AW)) u_dist (
    .clk(clk), .rst(rst), .in_vld(dist_vld), .in_dx(dist_dx), .in_dy(dist_dy),
    .in_tag(dist_tag), .out_vld(dout_vld), .out_dist(dout_dist), .out_tag(dout_tag)
  );

  ppws_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  always_comb begin
    last_recv = dout_vld && ((recv_cnt + CW'(1)) == point_count);
    near_upd  = (recv_cnt == '0) || (dout_dist < best);
    near_idx  = near_upd ? dout_tag : nearest;
    acc_next  = acc + 34'(dout_dist);
    hit       = !found && (acc_next >= 34'(lookahead_dist));
    steer_done = (got_b || crsp.done) && out_free;

    alpha_c = ppws_pkg::alpha_t'(bearing) - ppws_pkg::alpha_t'(car_heading);
    if (alpha_c > ppws_pkg::PI_Q16) begin
      alpha_w = alpha_c - ppws_pkg::TWO_PI_Q16;
    end else if (alpha_c < -ppws_pkg::PI_Q16) begin
      alpha_w = alpha_c + ppws_pkg::TWO_PI_Q16;
    end else begin
      alpha_w = alpha_c;
    end
    if (alpha > ppws_pkg::HALF_PI_Q16) begin
      alpha_f = ppws_pkg::PI_Q16 - alpha;
    end else if (alpha < -ppws_pkg::HALF_PI_Q16) begin
      alpha_f = -ppws_pkg::PI_Q16 - alpha;
    end else begin
      alpha_f = alpha;
    end

    steer_prod_c = $signed({1'b0, wheel_base}) * sin_v;
    spd_prod_c   = spd * $signed({1'b0, velocity_gain});
    sp_sum       = 50'(spd_prod) + 50'sd16384;
    sp_sh        = sp_sum >>> 15;
    pose_num     = {33'(p_wz) + 33'(p_xy), 1'b0};
    pose_den     = 34'sd1073741824 - {33'(p_yy) + 33'(p_zz), 1'b0};
  end

  always_comb begin
    state_next = state;
    case (state)
      ppws_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ppws_pkg::ACT_POSE: state_next = ppws_pkg::ST_POSE_MUL;
            ppws_pkg::ACT_TICK: begin
              if (enabled && have_points && have_pose) begin
                state_next = ppws_pkg::ST_NEAR;
              end
            end
            default: state_next = ppws_pkg::ST_IDLE;
          endcase
        end
      end
      ppws_pkg::ST_POSE_MUL:  state_next = ppws_pkg::ST_POSE_ATAN;
      ppws_pkg::ST_POSE_ATAN: state_next = ppws_pkg::ST_POSE_WAIT;
      ppws_pkg::ST_POSE_WAIT: if (crsp.done) state_next = ppws_pkg::ST_IDLE;
      ppws_pkg::ST_NEAR:      if (last_recv) state_next = ppws_pkg::ST_WALK;
      ppws_pkg::ST_WALK:      if (last_recv) state_next = ppws_pkg::ST_GOAL_RD;
      ppws_pkg::ST_GOAL_RD:   state_next = ppws_pkg::ST_GOAL_DATA;
      ppws_pkg::ST_GOAL_DATA: state_next = ppws_pkg::ST_BEAR_START;
      ppws_pkg::ST_BEAR_START: state_next = ppws_pkg::ST_BEAR_WAIT;
      ppws_pkg::ST_BEAR_WAIT: begin
        if ((got_b || crsp.done) && (got_ld || dout_vld)) begin
          state_next = ppws_pkg::ST_ALPHA;
        end
      end
      ppws_pkg::ST_ALPHA:     state_next = ppws_pkg::ST_SIN_START;
      ppws_pkg::ST_SIN_START: state_next = ppws_pkg::ST_SIN_WAIT;
      ppws_pkg::ST_SIN_WAIT:  if (crsp.done) state_next = ppws_pkg::ST_STEER_MUL;
      ppws_pkg::ST_STEER_MUL: state_next = ppws_pkg::ST_STEER_START;
      ppws_pkg::ST_STEER_START: state_next = ppws_pkg::ST_STEER_WAIT;
      ppws_pkg::ST_STEER_WAIT: if (steer_done) state_next = ppws_pkg::ST_IDLE;
      default: state_next = ppws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    mem_raddr = rd_addr;
    dist_vld  = 1'b0;
    dist_dx   = DW'(ram_x) - DW'(car_x);
    dist_dy   = DW'(ram_y) - DW'(car_y);
    dist_tag  = rd_tag;
    creq      = '0;
    case (state)
      ppws_pkg::ST_IDLE: in_ready = 1'b1;
      ppws_pkg::ST_POSE_ATAN: begin
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        creq.x0    = W'(pose_den);
        creq.y0    = W'(pose_num);
      end
      ppws_pkg::ST_NEAR: begin
        issue    = issue_cnt < {1'b0, point_count};
        dist_vld = rd_pend;
      end
      ppws_pkg::ST_WALK: begin
        issue    = issue_cnt <= {1'b0, point_count};
        dist_vld = rd_pend && !rd_first;
        dist_dx  = DW'(ram_x) - DW'(prev_x);
        dist_dy  = DW'(ram_y) - DW'(prev_y);
      end
      ppws_pkg::ST_GOAL_RD: mem_raddr = goal;
      ppws_pkg::ST_BEAR_START: begin
        dist_vld   = 1'b1;
        dist_dx    = dx_l;
        dist_dy    = dy_l;
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        creq.x0    = W'(dx_l);
        creq.y0    = W'(dy_l);
      end
      ppws_pkg::ST_SIN_START: begin
        creq.start = 1'b1;
        creq.z0    = {alpha_f[19:0], 8'h00};
      end
      ppws_pkg::ST_STEER_START: begin
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        creq.x0    = $signed({5'b0, ld, 16'h0000});
        creq.y0    = W'(steer_y);
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ppws_pkg::ST_IDLE;
      enabled        <= ppws_pkg::ENABLED_RST;
      velocity_gain  <= ppws_pkg::VELOCITY_GAIN_RST;
      lookahead_dist <= ppws_pkg::LOOKAHEAD_RST;
      wheel_base     <= ppws_pkg::WHEEL_BASE_RST;
      point_count    <= '0;
      have_points    <= 1'b0;
      have_pose      <= 1'b0;
      car_x          <= '0;
      car_y          <= '0;
      car_heading    <= '0;
      out_valid      <= 1'b0;
      rd_pend        <= 1'b0;
      found          <= 1'b0;
      got_b          <= 1'b0;
      got_ld         <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_write) begin
        case (cfg_index)
          ppws_pkg::CFG_ENABLED:       enabled        <= cfg_data[0];
          ppws_pkg::CFG_VELOCITY_GAIN: velocity_gain  <= cfg_data[15:0];
          ppws_pkg::CFG_LOOKAHEAD:     lookahead_dist <= cfg_data;
          ppws_pkg::CFG_WHEEL_BASE:    wheel_base     <= cfg_data;
          default: enabled <= enabled;
        endcase
      end
      if (accept && in_ch.action == ppws_pkg::ACT_LOAD && idx_ok && in_ch.point_last) begin
        point_count <= CW'(in_ch.point_index) + CW'(1);
        have_points <= 1'b1;
      end
      if (accept && in_ch.action == ppws_pkg::ACT_POSE) begin
        car_x <= in_ch.pos_x;
        car_y <= in_ch.pos_y;
      end
      if (state == ppws_pkg::ST_POSE_WAIT && crsp.done) begin
        car_heading <= crsp.angle;
        have_pose   <= 1'b1;
      end
      if (state == ppws_pkg::ST_NEAR) begin
        found <= 1'b0;
      end else if (state == ppws_pkg::ST_WALK && dout_vld && hit) begin
        found <= 1'b1;
      end
      if (state == ppws_pkg::ST_BEAR_START || state == ppws_pkg::ST_STEER_START) begin
        got_b  <= 1'b0;
        got_ld <= 1'b0;
      end else if (state == ppws_pkg::ST_BEAR_WAIT) begin
        if (crsp.done) got_b <= 1'b1;
        if (dout_vld) got_ld <= 1'b1;
      end else if (state == ppws_pkg::ST_STEER_WAIT && crsp.done) begin
        got_b <= 1'b1;
      end
      if (state == ppws_pkg::ST_STEER_WAIT && steer_done) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ppws_pkg::ST_IDLE: begin
        rd_addr   <= '0;
        issue_cnt <= '0;
        recv_cnt  <= '0;
        qx <= in_ch.quat_x;
        qy <= in_ch.quat_y;
        qz <= in_ch.quat_z;
        qw <= in_ch.quat_w;
      end
      ppws_pkg::ST_POSE_MUL: begin
        p_wz <= qw * qz;
        p_xy <= qx * qy;
        p_yy <= qy * qy;
        p_zz <= qz * qz;
      end
      ppws_pkg::ST_NEAR: begin
        if (issue) begin
          rd_addr   <= rd_addr + AW'(1);
          rd_tag    <= rd_addr;
          issue_cnt <= issue_cnt + (CW+1)'(1);
        end
        if (dout_vld) begin
          recv_cnt <= recv_cnt + CW'(1);
          if (near_upd) begin
            best    <= dout_dist;
            nearest <= dout_tag;
          end
        end
        if (last_recv) begin
          rd_addr   <= near_idx;
          issue_cnt <= '0;
          recv_cnt  <= '0;
          acc       <= '0;
        end
      end
      ppws_pkg::ST_WALK: begin
        if (issue) begin
          rd_addr   <= ((CW'(rd_addr) + CW'(1)) == point_count) ? '0 : rd_addr + AW'(1);
          rd_tag    <= rd_addr;
          rd_first  <= (issue_cnt == '0);
          issue_cnt <= issue_cnt + (CW+1)'(1);
        end
        if (rd_pend) begin
          prev_x <= ram_x;
          prev_y <= ram_y;
        end
        if (dout_vld) begin
          recv_cnt <= recv_cnt + CW'(1);
          if (!found) begin
            acc <= acc_next;
          end
          if (hit) begin
            goal <= dout_tag;
          end else if (last_recv && !found) begin
            goal <= nearest;
          end
        end
      end
      ppws_pkg::ST_GOAL_DATA: begin
        dx_l <= DW'(ram_x) - DW'(car_x);
        dy_l <= DW'(ram_y) - DW'(car_y);
        spd  <= spd_rdata;
      end
      ppws_pkg::ST_BEAR_WAIT: begin
        if (crsp.done) bearing <= crsp.angle;
        if (dout_vld) ld <= dout_dist;
      end
      ppws_pkg::ST_ALPHA: alpha <= alpha_w;
      ppws_pkg::ST_SIN_WAIT: begin
        if (crsp.done) sin_v <= crsp.sine;
      end
      ppws_pkg::ST_STEER_MUL: begin
        steer_y  <= {steer_prod_c, 1'b0};
        spd_prod <= spd_prod_c;
      end
      ppws_pkg::ST_STEER_WAIT: begin
        if (steer_done) begin
          if (crsp.angle > ppws_pkg::STEER_LIMIT) begin
            out_steer <= ppws_pkg::STEER_LIMIT[15:0];
          end else if (crsp.angle < -ppws_pkg::STEER_LIMIT) begin
            out_steer <= 16'(-ppws_pkg::STEER_LIMIT);
          end else begin
            out_steer <= crsp.angle[15:0];
          end
          if (sp_sh > 50'sd2147483647) begin
            out_drive <= 32'sh7FFF_FFFF;
          end else if (sp_sh < -50'sd2147483648) begin
            out_drive <= 32'sh8000_0000;
          end else begin
            out_drive <= sp_sh[31:0];
          end
        end
      end
      default: rd_tag <= rd_tag;
    endcase
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_speed = out_drive;
  assign out_ch.steer_angle = out_steer;
endmodule
`default_nettype wire
